// ----- src/tcprx_pkg.sv -----
// Shared types, codes and state encoding helpers for the TCP receive-side controller.
`default_nettype none

package tcprx_pkg;

    // Input word kinds.
    localparam logic [1:0] MODE_SEGMENT = 2'd0;
    localparam logic [1:0] MODE_COMMAND = 2'd1;
    localparam logic [1:0] MODE_CREDIT  = 2'd2;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_SEND_SEQ = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECV_WINDOW_MAX  = 1'd1;
    localparam logic [15:0] RECV_WINDOW_MAX_RESET = 16'hFFFF;

    // Connection state codes as seen on the ports.
    localparam logic [3:0] CS_CLOSED     = 4'd0;
    localparam logic [3:0] CS_LISTEN     = 4'd1;
    localparam logic [3:0] CS_SYN_SENT   = 4'd2;
    localparam logic [3:0] CS_SYN_RCVD   = 4'd3;
    localparam logic [3:0] CS_ESTAB      = 4'd4;
    localparam logic [3:0] CS_FIN_WAIT1  = 4'd5;
    localparam logic [3:0] CS_FIN_WAIT2  = 4'd6;
    localparam logic [3:0] CS_CLOSE_WAIT = 4'd7;
    localparam logic [3:0] CS_CLOSING    = 4'd8;
    localparam logic [3:0] CS_LAST_ACK   = 4'd9;
    localparam logic [3:0] CS_TIME_WAIT  = 4'd10;

    // Internal one-hot connection state.
    typedef enum logic [10:0] {
        ST_CLOSED     = 11'h001,
        ST_LISTEN     = 11'h002,
        ST_SYN_SENT   = 11'h004,
        ST_SYN_RCVD   = 11'h008,
        ST_ESTAB      = 11'h010,
        ST_FIN_WAIT1  = 11'h020,
        ST_FIN_WAIT2  = 11'h040,
        ST_CLOSE_WAIT = 11'h080,
        ST_CLOSING    = 11'h100,
        ST_LAST_ACK   = 11'h200,
        ST_TIME_WAIT  = 11'h400
    } t_conn_state;

    // One input word.
    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] seq_num;
        logic [31:0] ack_num;
        logic [15:0] peer_window;
        logic        flag_syn;
        logic        flag_ack;
        logic        flag_rst;
        logic        flag_fin;
        logic [15:0] payload_len;
        logic [31:0] send_next;
        logic [3:0]  new_state;
        logic [15:0] credit;
    } t_rx_word;

    // One result word.
    typedef struct packed {
        logic        send_ack;
        logic        deliver_data;
        logic        dropped;
        logic        state_changed;
        logic [3:0]  conn_state;
        logic [31:0] ack_point;
        logic [15:0] send_window;
        logic [31:0] recv_next;
        logic [15:0] recv_window;
    } t_tx_word;

    // Configuration register contents.
    typedef struct packed {
        logic [31:0] initial_send_seq;
        logic [15:0] recv_window_max;
    } t_cfg;

    // Per-connection context kept between words.
    typedef struct packed {
        t_conn_state st;
        logic [31:0] snd_una;
        logic [15:0] snd_wnd;
        logic [31:0] snd_wl1;
        logic [31:0] snd_wl2;
        logic [31:0] rcv_nxt;
        logic [15:0] rcv_wnd;
    } t_conn_ctx;

    // One-hot state to port code.
    function automatic logic [3:0] state_to_code(input t_conn_state st);
        logic [3:0] code;
        case (st)
            ST_CLOSED:     code = CS_CLOSED;
            ST_LISTEN:     code = CS_LISTEN;
            ST_SYN_SENT:   code = CS_SYN_SENT;
            ST_SYN_RCVD:   code = CS_SYN_RCVD;
            ST_ESTAB:      code = CS_ESTAB;
            ST_FIN_WAIT1:  code = CS_FIN_WAIT1;
            ST_FIN_WAIT2:  code = CS_FIN_WAIT2;
            ST_CLOSE_WAIT: code = CS_CLOSE_WAIT;
            ST_CLOSING:    code = CS_CLOSING;
            ST_LAST_ACK:   code = CS_LAST_ACK;
            ST_TIME_WAIT:  code = CS_TIME_WAIT;
            default:       code = CS_CLOSED;
        endcase
        return code;
    endfunction

    // Port code to one-hot state; codes above time_wait are screened by the caller.
    function automatic t_conn_state code_to_state(input logic [3:0] code);
        t_conn_state st;
        case (code)
            CS_CLOSED:     st = ST_CLOSED;
            CS_LISTEN:     st = ST_LISTEN;
            CS_SYN_SENT:   st = ST_SYN_SENT;
            CS_SYN_RCVD:   st = ST_SYN_RCVD;
            CS_ESTAB:      st = ST_ESTAB;
            CS_FIN_WAIT1:  st = ST_FIN_WAIT1;
            CS_FIN_WAIT2:  st = ST_FIN_WAIT2;
            CS_CLOSE_WAIT: st = ST_CLOSE_WAIT;
            CS_CLOSING:    st = ST_CLOSING;
            CS_LAST_ACK:   st = ST_LAST_ACK;
            CS_TIME_WAIT:  st = ST_TIME_WAIT;
            default:       st = ST_CLOSED;
        endcase
        return st;
    endfunction

endpackage

`default_nettype wire

// ----- src/tcprx_cfg.sv -----
// Configuration registers of the TCP receive-side controller.
`default_nettype none

module tcprx_cfg
    import tcprx_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]          i_cfg_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Writes are always taken.
    assign o_cfg_ready = 1'b1;

    // Decode the register index.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_INITIAL_SEND_SEQ: n_cfg.initial_send_seq = i_cfg_data;
                CFG_RECV_WINDOW_MAX:  n_cfg.recv_window_max  = i_cfg_data[15:0];
                default:              n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.initial_send_seq <= '0;
            r_cfg.recv_window_max  <= RECV_WINDOW_MAX_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- src/tcprx_step.sv -----
// Next-context and result logic for one word of the TCP receive-side controller.
`default_nettype none

module tcprx_step
    import tcprx_pkg::*;
(
    input  wire t_conn_ctx i_ctx,
    input  wire t_cfg      i_cfg,
    input  wire t_rx_word  i_word,
    output t_conn_ctx      o_ctx,
    output t_tx_word       o_res
);

    logic [31:0] len32;
    logic [31:0] win_limit;
    logic [31:0] seg_last;
    logic        seq_ok;
    logic [31:0] una_acked;
    logic        wnd_update;
    logic        una_at_next;
    logic [16:0] credit_sum;
    t_conn_state mid_st;
    t_conn_ctx   n_ctx;
    logic        fl_ack;
    logic        fl_deliver;
    logic        fl_drop;

    assign len32     = {16'd0, i_word.payload_len};
    assign win_limit = i_ctx.rcv_nxt + {16'd0, i_ctx.rcv_wnd};
    assign seg_last  = i_word.seq_num + len32 - 32'd1;

    // Receive window acceptance test, plain unsigned compares.
    always_comb begin
        if (i_word.payload_len == 16'd0) begin
            if (i_ctx.rcv_wnd == 16'd0) begin
                seq_ok = (i_word.seq_num == i_ctx.rcv_nxt);
            end else begin
                seq_ok = !(i_ctx.rcv_nxt > i_word.seq_num || i_word.seq_num >= win_limit);
            end
        end else if (i_ctx.rcv_wnd == 16'd0) begin
            seq_ok = 1'b0;
        end else begin
            seq_ok = !(i_ctx.rcv_nxt > i_word.seq_num || i_word.seq_num >= win_limit ||
                       i_ctx.rcv_nxt > seg_last || seg_last >= win_limit);
        end
    end

    // Acknowledgment advance and send window update check.
    assign una_acked = (i_ctx.snd_una < i_word.ack_num && i_word.ack_num <= i_word.send_next)
                       ? i_word.ack_num : i_ctx.snd_una;
    assign wnd_update = (una_acked < i_word.seq_num && i_word.seq_num <= i_word.send_next) &&
                        (i_ctx.snd_wl1 < i_word.seq_num ||
                         (i_ctx.snd_wl1 == i_word.seq_num && i_ctx.snd_wl2 <= i_word.ack_num));
    assign una_at_next = (una_acked == i_word.send_next);

    assign credit_sum = {1'b0, i_ctx.rcv_wnd} + {1'b0, i_word.credit};

    // Main decision logic.
    always_comb begin
        n_ctx      = i_ctx;
        fl_ack     = 1'b0;
        fl_deliver = 1'b0;
        fl_drop    = 1'b0;
        mid_st     = i_ctx.st;
        case (i_word.mode)
            MODE_SEGMENT: begin
                if (i_ctx.st == ST_SYN_SENT) begin
                    // Handshake reply: only a valid synack completes the open.
                    if (i_word.flag_ack && (i_word.ack_num <= i_cfg.initial_send_seq ||
                        i_word.ack_num > i_word.send_next || i_ctx.snd_una > i_word.ack_num)) begin
                        fl_drop = 1'b1;
                    end else if (i_word.flag_rst || !i_word.flag_syn || !i_word.flag_ack) begin
                        fl_drop = 1'b1;
                    end else begin
                        n_ctx.snd_una = i_ctx.snd_una + 32'd1;
                        n_ctx.snd_wnd = i_word.peer_window;
                        n_ctx.rcv_nxt = i_word.seq_num + 32'd1;
                        n_ctx.st      = ST_ESTAB;
                        fl_ack        = 1'b1;
                    end
                end else if (i_ctx.st inside {ST_CLOSED, ST_LISTEN, ST_SYN_RCVD}) begin
                    fl_drop = 1'b1;
                end else if (!seq_ok) begin
                    fl_drop = 1'b1;
                    fl_ack  = 1'b1;
                end else if (i_word.flag_rst || i_word.flag_syn || !i_word.flag_ack ||
                             i_ctx.st == ST_TIME_WAIT) begin
                    fl_drop = 1'b1;
                end else begin
                    n_ctx.snd_una = una_acked;
                    if (wnd_update) begin
                        n_ctx.snd_wnd = i_word.peer_window;
                        n_ctx.snd_wl1 = i_word.seq_num;
                        n_ctx.snd_wl2 = i_word.ack_num;
                    end
                    if (i_ctx.st == ST_FIN_WAIT1 && una_at_next) begin
                        mid_st = ST_FIN_WAIT2;
                    end
                    n_ctx.st = mid_st;
                    if (i_ctx.st inside {ST_CLOSING, ST_LAST_ACK}) begin
                        // Waiting on our FIN to be acknowledged, nothing else happens.
                        if (una_at_next) begin
                            n_ctx.st = (i_ctx.st == ST_CLOSING) ? ST_TIME_WAIT : ST_CLOSED;
                        end
                    end else begin
                        // In-order data.
                        if (i_word.payload_len != 16'd0 &&
                            (mid_st inside {ST_ESTAB, ST_FIN_WAIT1, ST_FIN_WAIT2}) &&
                            i_word.seq_num == i_ctx.rcv_nxt) begin
                            n_ctx.rcv_nxt = i_ctx.rcv_nxt + len32;
                            n_ctx.rcv_wnd = (i_word.payload_len > i_ctx.rcv_wnd) ? 16'd0
                                            : i_ctx.rcv_wnd - i_word.payload_len;
                            fl_ack     = 1'b1;
                            fl_deliver = 1'b1;
                        end
                        // Peer FIN.
                        if (i_word.flag_fin) begin
                            n_ctx.rcv_nxt = i_word.seq_num + len32 + 32'd1;
                            fl_ack        = 1'b1;
                            if (mid_st == ST_ESTAB) begin
                                n_ctx.st = ST_CLOSE_WAIT;
                            end else if (mid_st == ST_FIN_WAIT1 && una_at_next) begin
                                n_ctx.st = ST_TIME_WAIT;
                            end else if (mid_st == ST_FIN_WAIT2) begin
                                n_ctx.st = ST_TIME_WAIT;
                            end
                        end
                    end
                end
            end
            MODE_COMMAND: begin
                // Forced state; out-of-range codes are ignored.
                if (i_word.new_state <= CS_TIME_WAIT) begin
                    n_ctx.st = code_to_state(i_word.new_state);
                    if (i_word.new_state == CS_SYN_SENT) begin
                        n_ctx.snd_una = i_cfg.initial_send_seq;
                        n_ctx.rcv_wnd = i_cfg.recv_window_max;
                    end
                end
            end
            MODE_CREDIT: begin
                // Window reopen, clamped to the buffer size unless the window is already larger.
                if (credit_sum > {1'b0, i_cfg.recv_window_max}) begin
                    n_ctx.rcv_wnd = (i_ctx.rcv_wnd > i_cfg.recv_window_max)
                                    ? i_ctx.rcv_wnd : i_cfg.recv_window_max;
                end else begin
                    n_ctx.rcv_wnd = credit_sum[15:0];
                end
            end
            default: n_ctx = i_ctx;
        endcase
    end

    assign o_ctx = n_ctx;

    // Result word reflects the context after this word.
    assign o_res.send_ack      = fl_ack;
    assign o_res.deliver_data  = fl_deliver;
    assign o_res.dropped       = fl_drop;
    assign o_res.state_changed = (n_ctx.st != i_ctx.st);
    assign o_res.conn_state    = state_to_code(n_ctx.st);
    assign o_res.ack_point     = n_ctx.snd_una;
    assign o_res.send_window   = n_ctx.snd_wnd;
    assign o_res.recv_next     = n_ctx.rcv_nxt;
    assign o_res.recv_window   = n_ctx.rcv_wnd;

endmodule

`default_nettype wire

// ----- src/tcp_rx_connection_state_machine.sv -----
// Top level of the receive-side TCP connection controller.
//
// Usage: each input word is a parsed segment header, a local state command or an
// application window credit, selected by its mode field. A word is taken at a
// rising edge with i_in_valid high and o_in_stall low. Every word gives exactly
// one result word, taken at an edge with o_out_valid high and i_out_stall low.
// Configuration registers are written over the i_cfg_* channel, which is always
// ready; write them only while no word is in flight.
// A word lands in the input register at its accept edge, and its result is then
// loaded into the output register once that register is free or being emptied.
// Throughput is one word per cycle while the receiver does not stall, set by the
// context update loop through the step logic.
// Reset (synchronous, active low) empties both registers, puts the connection
// in closed with all sequence and window state zero, clears the initial send
// sequence and sets the receive buffer size to 65535.
// When the receiver stalls, the result is held and one more word can sit in the
// input register; after that o_in_stall rises until the result is taken.
`default_nettype none

module tcp_rx_connection_state_machine
    import tcprx_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_rx_word             i_in_word,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_tx_word                  o_out_word,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]          i_cfg_data
);

    t_cfg      cfg;
    t_conn_ctx r_ctx;
    t_conn_ctx n_ctx;
    t_tx_word  step_res;
    t_rx_word  r_in_word;
    logic      r_in_valid;
    t_tx_word  r_out_word;
    logic      r_out_valid;
    logic      out_free;
    logic      step_go;
    logic      in_take;

    tcprx_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tcprx_step u_step (
        .i_ctx  (r_ctx),
        .i_cfg  (cfg),
        .i_word (r_in_word),
        .o_ctx  (n_ctx),
        .o_res  (step_res)
    );

    // Flow control between input register, step logic and output register.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign step_go    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word <= i_in_word;
        end
    end

    // Connection context, updated once per processed word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx.st      <= ST_CLOSED;
            r_ctx.snd_una <= '0;
            r_ctx.snd_wnd <= '0;
            r_ctx.snd_wl1 <= '0;
            r_ctx.snd_wl2 <= '0;
            r_ctx.rcv_nxt <= '0;
            r_ctx.rcv_wnd <= '0;
        end else if (step_go) begin
            r_ctx <= n_ctx;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_go) begin
            r_out_word <= step_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Delivered data is always acknowledged.
    a_deliver_acks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.deliver_data) |-> o_out_word.send_ack)
        else $error("data delivered without an acknowledgment");

    // A word is never both delivered and dropped.
    a_deliver_not_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_word.deliver_data && o_out_word.dropped))
        else $error("result both delivered and dropped");

    // A full input register must hold off new words while the result is stuck.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && i_out_stall) |-> o_in_stall)
        else $error("input not stalled with both registers full");

    // The context only moves when a word passes to the output register.
    a_ctx_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !step_go |=> $stable(r_ctx))
        else $error("connection context changed without a word");

endmodule

`default_nettype wire
